>>> rtl/core/ldtc_pkg.sv
// Shared types, widths and constants of the LED dimmer timeout controller.
package ldtc_pkg;

    localparam int NUM_LEVELS     = 4;
    localparam int DEBOUNCE_WIDTH = 16;
    localparam int WORD_W         = 16;
    localparam int LEVEL_W        = 3;

    localparam int S_DATA_W  = 8;
    localparam int M_FIELD_W = 1 + WORD_W + 2 + WORD_W + 1;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [DEBOUNCE_WIDTH-1:0] DB_FORCE = 16'hE000;
    localparam logic [DEBOUNCE_WIDTH-1:0] DB_PRESS = 16'hF000;

    localparam logic [WORD_W-1:0] GAMMA0_RST  = 16'd70;
    localparam logic [WORD_W-1:0] GAMMA1_RST  = 16'd280;
    localparam logic [WORD_W-1:0] GAMMA2_RST  = 16'd629;
    localparam logic [WORD_W-1:0] GAMMA3_RST  = 16'd1118;
    localparam logic [WORD_W-1:0] TIMEOUT_RST = 16'd3600;
    localparam logic [WORD_W-1:0] TPS_RST     = 16'd1000;

    localparam logic [LEVEL_W:0] LEVEL_LIMIT = (LEVEL_W + 1)'(NUM_LEVELS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAMMA0  = 3'd0,
        CFG_GAMMA1  = 3'd1,
        CFG_GAMMA2  = 3'd2,
        CFG_GAMMA3  = 3'd3,
        CFG_TIMEOUT = 3'd4,
        CFG_TPS     = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_WAKE = 1'b1
    } item_kind_t;

endpackage

>>> rtl/core/led_dimmer_timeout_controller.sv
// Top level of the LED dimmer timeout controller: state update and result register.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  s_tuser = kind, s_tdata[0] = button_level
//  m_        out        m_tvalid/m_tready  m_tdata = led_on, duty, level, seconds, press
//  cfg_      in         cfg_wr_en          cfg_index selects register, cfg_wdata value
//
// Each beat takes one cycle: the state registers and the result register load at the
// edge that accepts the beat, so a beat may be taken in every cycle.
// The result register is the only buffer; a new beat is taken while it is empty or
// while its result is taken in the same cycle. A stall on m_ holds s_tready low.
// aresetn is synchronous and active low; no clearing pass is needed after it.
module led_dimmer_timeout_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [0] button_level, upper bits zero
    input  logic [ldtc_pkg::S_DATA_W-1:0] s_tdata,
    // [0] kind
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] led_on, [16:1] duty_compare, [18:17] level, [34:19] seconds_left,
    // [35] press_seen, upper bits zero
    output logic [ldtc_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [ldtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ldtc_pkg::WORD_W-1:0]   cfg_wdata
);
    import ldtc_pkg::*;

    logic [WORD_W-1:0] gamma0_reg, gamma1_reg, gamma2_reg, gamma3_reg;
    logic [WORD_W-1:0] timeout_reg, tps_reg;

    logic                      running_reg, running_next;
    logic [LEVEL_W-1:0]        level_reg, level_next;
    logic [WORD_W-1:0]         seconds_reg, seconds_next;
    logic [WORD_W-1:0]         ticks_reg, ticks_next;
    logic [DEBOUNCE_WIDTH-1:0] db_reg, db_next;
    logic [WORD_W-1:0]         compare_reg, compare_next;
    logic                      press_next;

    logic                  m_valid_reg;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;
    logic                  s_accept;

    logic [LEVEL_W:0]      level_inc;
    logic [WORD_W-1:0]     ticks_dec;
    logic [WORD_W-1:0]     gamma_cur;
    logic [WORD_W-1:0]     gamma_inc;

    // Levels without a register of their own use the last gamma.
    function automatic logic [WORD_W-1:0] gamma_sel(
        input logic [LEVEL_W-1:0] lvl,
        input logic [WORD_W-1:0]  g0,
        input logic [WORD_W-1:0]  g1,
        input logic [WORD_W-1:0]  g2,
        input logic [WORD_W-1:0]  g3
    );
        logic [WORD_W-1:0] g;
        priority if (lvl == LEVEL_W'(0)) begin
            g = g0;
        end else if (lvl == LEVEL_W'(1)) begin
            g = g1;
        end else if (lvl == LEVEL_W'(2)) begin
            g = g2;
        end else begin
            g = g3;
        end
        return g;
    endfunction

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign level_inc = {1'b0, level_reg} + (LEVEL_W + 1)'(1);
    assign ticks_dec = ticks_reg - WORD_W'(1);
    assign gamma_cur = gamma_sel(level_reg, gamma0_reg, gamma1_reg, gamma2_reg, gamma3_reg);
    assign gamma_inc = gamma_sel(level_inc[LEVEL_W-1:0],
                                 gamma0_reg, gamma1_reg, gamma2_reg, gamma3_reg);

    always_comb begin
        running_next = running_reg;
        level_next   = level_reg;
        seconds_next = seconds_reg;
        ticks_next   = ticks_reg;
        db_next      = db_reg;
        compare_next = compare_reg;
        press_next   = 1'b0;

        if (s_tuser == KIND_WAKE) begin
            if (!running_reg) begin
                running_next = 1'b1;
                level_next   = '0;
                seconds_next = timeout_reg;
                ticks_next   = tps_reg;
                compare_next = gamma0_reg;
            end
        end else if (running_reg) begin
            ticks_next = ticks_dec;
            if (ticks_dec == '0) begin
                seconds_next = seconds_reg - WORD_W'(1);
                ticks_next   = tps_reg;
            end
            // Fade: near the end the duty follows the seconds still left.
            if (seconds_next < gamma_cur) begin
                compare_next = seconds_next;
            end

            db_next = {db_reg[DEBOUNCE_WIDTH-2:0], 1'b0}
                    | (DEBOUNCE_WIDTH'(s_tdata[0]) << 3) | DB_FORCE;

            if (db_next == DB_PRESS) begin
                press_next   = 1'b1;
                seconds_next = timeout_reg;
                ticks_next   = tps_reg;
                if (level_inc >= LEVEL_LIMIT) begin
                    level_next = LEVEL_LIMIT[LEVEL_W-1:0];
                end else begin
                    level_next   = level_inc[LEVEL_W-1:0];
                    compare_next = gamma_inc;
                end
            end

            if ((press_next && level_inc >= LEVEL_LIMIT) || seconds_next == '0) begin
                running_next = 1'b0;
            end
        end
    end

    always_comb begin
        m_data_next = {(M_DATA_W - M_FIELD_W)'(0), press_next, seconds_next,
                       level_next[1:0], compare_next, running_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma0_reg  <= GAMMA0_RST;
            gamma1_reg  <= GAMMA1_RST;
            gamma2_reg  <= GAMMA2_RST;
            gamma3_reg  <= GAMMA3_RST;
            timeout_reg <= TIMEOUT_RST;
            tps_reg     <= TPS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GAMMA0:  gamma0_reg  <= cfg_wdata;
                CFG_GAMMA1:  gamma1_reg  <= cfg_wdata;
                CFG_GAMMA2:  gamma2_reg  <= cfg_wdata;
                CFG_GAMMA3:  gamma3_reg  <= cfg_wdata;
                CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                CFG_TPS:     tps_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b1;
            level_reg   <= '0;
            seconds_reg <= TIMEOUT_RST;
            ticks_reg   <= TPS_RST;
            db_reg      <= '0;
            compare_reg <= GAMMA0_RST;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                running_reg <= running_next;
                level_reg   <= level_next;
                seconds_reg <= seconds_next;
                ticks_reg   <= ticks_next;
                db_reg      <= db_next;
                compare_reg <= compare_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

>>> rtl/core/ldtc_checker.sv
// Port-level checker for the LED dimmer timeout controller, bound to the top level.
module ldtc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [ldtc_pkg::S_DATA_W-1:0] s_tdata,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ldtc_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          cfg_wr_en,
    input logic [ldtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [ldtc_pkg::WORD_W-1:0]   cfg_wdata
);
    import ldtc_pkg::*;

    // A result that waits is held until it is taken.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

    // With no result waiting the block always takes a beat.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // Every accepted beat gives a result in the next cycle.
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat produced no result");

endmodule

bind led_dimmer_timeout_controller ldtc_checker u_ldtc_checker (.*);
